### rtl/dvru_pkg.sv
// ----------------------------------------------------------------------------
// dvru_pkg: shared types and constants of the route update block
// Item and result layouts, action and verdict codes, cost helpers.
// ----------------------------------------------------------------------------
package dvru_pkg;

	localparam int NODE_COUNT = 64;
	localparam int COST_BITS  = 16;
	localparam int ID_W       = 6;
	localparam int DIST_W     = 16;
	localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	typedef logic [COST_BITS-1:0] cost_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [ID_W-1:0]      id_t;

	localparam cost_t COST_MAX = '1;

	// action codes
	localparam logic [1:0] ACT_LINK   = 2'd0;
	localparam logic [1:0] ACT_ADVERT = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;
	// unused code: changes nothing, all result fields zero
	localparam logic [1:0] ACT_SPARE  = 2'd3;

	// verdict codes
	localparam logic [2:0] VERD_NONE   = 3'd0;
	localparam logic [2:0] VERD_BOTH   = 3'd1;
	localparam logic [2:0] VERD_UPDATE = 3'd2;
	localparam logic [2:0] VERD_HELLO  = 3'd3;
	localparam logic [2:0] VERD_IGNORE = 3'd4;

	typedef struct packed {
		logic [1:0]        action;
		id_t               neighbor_id;
		id_t               dest_id;
		logic [DIST_W-1:0] distance;
		logic              last_in_message;
	} item_t;

	typedef struct packed {
		logic [2:0]        verdict;
		logic              route_changed;
		logic              entry_valid;
		id_t               entry_next_hop;
		logic [DIST_W-1:0] entry_cost;
	} result_t;

	// table write port
	typedef struct packed {
		logic  en;
		idx_t  idx;
		id_t   next_hop;
		cost_t cost;
	} wr_t;

	// per-message bookkeeping
	typedef struct packed {
		logic mark_en;
		logic msg_end;
		logic hello_set;
	} msg_ctl_t;

	function automatic logic id_ok(input id_t id);
		return 32'(id) < NODE_COUNT;
	endfunction

	function automatic idx_t id_to_idx(input id_t id);
		logic [31:0] w;
		w = 32'(id);
		return w[IDX_W-1:0];
	endfunction

	// distance field into a cost, saturated at the maximum cost
	function automatic cost_t dist_to_cost(input logic [DIST_W-1:0] d);
		logic [31:0] w;
		w = 32'(d);
		if (w > 32'(COST_MAX)) begin
			return COST_MAX;
		end
		return w[COST_BITS-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] cost_to_field(input cost_t c);
		logic [31:0] w;
		w = 32'(c);
		return w[DIST_W-1:0];
	endfunction

endpackage

### rtl/dvru_route_ram.sv
// ----------------------------------------------------------------------------
// dvru_route_ram: next hop and cost storage
// One write port, two read ports (neighbor cost, destination entry), read
// data registered. No reset: entries are qualified by valid flops outside.
// ----------------------------------------------------------------------------
module dvru_route_ram (
	input  logic                 clk,
	input  dvru_pkg::wr_t        wr,
	input  logic                 rd_en,
	input  dvru_pkg::idx_t       nb_idx,
	input  dvru_pkg::idx_t       dest_idx,
	output dvru_pkg::cost_t      nb_cost,
	output dvru_pkg::id_t        dest_hop,
	output dvru_pkg::cost_t      dest_cost
);
	import dvru_pkg::*;

	id_t   hop_mem  [NODE_COUNT];
	cost_t cost_mem [NODE_COUNT];

	cost_t nb_cost_q;
	id_t   dest_hop_q;
	cost_t dest_cost_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			hop_mem[wr.idx]  <= wr.next_hop;
			cost_mem[wr.idx] <= wr.cost;
		end
	end

	// read ports, captured when a transaction is accepted
	always_ff @(posedge clk) begin
		if (rd_en) begin
			nb_cost_q   <= cost_mem[nb_idx];
			dest_hop_q  <= hop_mem[dest_idx];
			dest_cost_q <= cost_mem[dest_idx];
		end
	end

	assign nb_cost   = nb_cost_q;
	assign dest_hop  = dest_hop_q;
	assign dest_cost = dest_cost_q;

endmodule

### rtl/dvru_calc.sv
// ----------------------------------------------------------------------------
// dvru_calc: route decision for one item
// Adds the neighbor cost, compares with the stored route, builds the table
// write, the per-message controls and the result.
// ----------------------------------------------------------------------------
module dvru_calc (
	input  dvru_pkg::item_t              item,
	input  logic [dvru_pkg::NODE_COUNT-1:0] valid_vec,
	input  logic [dvru_pkg::NODE_COUNT-1:0] mark_vec,
	input  logic                         hello_pending,
	input  dvru_pkg::cost_t              nb_cost,
	input  dvru_pkg::id_t                dest_hop,
	input  dvru_pkg::cost_t              dest_cost,
	output dvru_pkg::wr_t                wr,
	output dvru_pkg::msg_ctl_t           ctl,
	output dvru_pkg::result_t            res
);
	import dvru_pkg::*;

	logic                  dest_ok;
	logic                  nb_ok;
	idx_t                  dest_idx;
	idx_t                  nb_idx;
	logic                  dest_valid;
	cost_t                 base;
	cost_t                 dist_c;
	logic [COST_BITS:0]    sum;
	cost_t                 total;
	logic [NODE_COUNT-1:0] valid_nxt;
	logic [NODE_COUNT-1:0] mark_nxt;
	logic                  upd;
	logic                  hello;

	assign dest_ok    = id_ok(item.dest_id);
	assign nb_ok      = id_ok(item.neighbor_id);
	assign dest_idx   = id_to_idx(item.dest_id);
	assign nb_idx     = id_to_idx(item.neighbor_id);
	assign dest_valid = dest_ok && valid_vec[dest_idx];
	assign dist_c     = dist_to_cost(item.distance);

	// unknown neighbor counts as cost 0
	assign base  = (nb_ok && valid_vec[nb_idx]) ? nb_cost : '0;
	assign sum   = {1'b0, dist_c} + {1'b0, base};
	assign total = sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0];

	// action decode
	always_comb begin
		wr  = '0;
		ctl = '0;
		wr.idx      = dest_idx;
		wr.next_hop = item.dest_id;
		wr.cost     = dist_c;
		unique case (item.action)
			ACT_LINK: begin
				wr.en = dest_ok;
			end
			ACT_ADVERT: begin
				wr.next_hop   = item.neighbor_id;
				wr.cost       = total;
				wr.en         = dest_ok && (!dest_valid || dest_cost > total);
				ctl.mark_en   = dest_ok;
				ctl.hello_set = wr.en;
				ctl.msg_end   = item.last_in_message;
			end
			ACT_QUERY: begin
			end
			default: begin
			end
		endcase
	end

	// message-end reduction over the table as it stands after this item
	always_comb begin
		valid_nxt = valid_vec;
		mark_nxt  = mark_vec;
		if (wr.en) begin
			valid_nxt[dest_idx] = 1'b1;
		end
		if (ctl.mark_en) begin
			mark_nxt[dest_idx] = 1'b1;
		end
	end

	assign upd   = |(valid_nxt & ~mark_nxt);
	assign hello = hello_pending || ctl.hello_set;

	// result
	always_comb begin
		res = '0;
		if (item.action != ACT_SPARE) begin
			if (ctl.msg_end) begin
				if (upd && hello) begin
					res.verdict = VERD_BOTH;
				end else if (upd) begin
					res.verdict = VERD_UPDATE;
				end else if (hello) begin
					res.verdict = VERD_HELLO;
				end else begin
					res.verdict = VERD_IGNORE;
				end
			end
			res.route_changed = wr.en;
			if (wr.en) begin
				res.entry_valid    = 1'b1;
				res.entry_next_hop = wr.next_hop;
				res.entry_cost     = cost_to_field(wr.cost);
			end else if (dest_valid) begin
				res.entry_valid    = 1'b1;
				res.entry_next_hop = dest_hop;
				res.entry_cost     = cost_to_field(dest_cost);
			end
		end
	end

endmodule

### rtl/distance_vector_route_update.sv
// ----------------------------------------------------------------------------
// distance_vector_route_update: distance-vector routing table update
// Link, advert and query transactions against a per-destination route table.
//
//   channel | signals                 | payload
//   req     | req_valid / req_ready   | dvru_pkg::item_t
//   rsp     | rsp_valid / rsp_ready   | dvru_pkg::result_t
//
// One transaction per cycle sustained while rsp is not stalled. The input and
// table read registers load when a request is accepted; the result register
// and rsp_valid load when the decision stage advances.
// The table read for a request happens at its accept edge; a write from the
// item ahead of it is forwarded from a write-holding register.
// Valid bits and per-message marks are flops cleared by reset: no clearing
// pass, the block is ready right after reset.
// A stalled rsp holds the decision stage; req_ready drops only then.
// ----------------------------------------------------------------------------
module distance_vector_route_update (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  dvru_pkg::item_t    req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output dvru_pkg::result_t  rsp
);
	import dvru_pkg::*;

	logic                  s1_valid_s1;
	item_t                 item_s1;
	logic                  s1_adv;
	logic                  req_acc;

	logic [NODE_COUNT-1:0] valid_q;
	logic [NODE_COUNT-1:0] mark_q;
	logic                  hello_q;

	logic                  fwd_valid_q;
	idx_t                  fwd_idx_q;
	id_t                   fwd_hop_q;
	cost_t                 fwd_cost_q;

	logic                  rsp_valid_q;
	result_t               rsp_q;

	cost_t                 ram_nb_cost;
	id_t                   ram_dest_hop;
	cost_t                 ram_dest_cost;
	cost_t                 nb_cost;
	id_t                   dest_hop;
	cost_t                 dest_cost;
	logic                  nb_hit;
	logic                  dest_hit;

	wr_t                   wr;
	wr_t                   wr_gated;
	msg_ctl_t              ctl;
	result_t               res;

	// handshake
	assign s1_adv    = s1_valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid_s1 || s1_adv;
	assign req_acc   = req_valid && req_ready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			s1_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			item_s1 <= req;
		end
	end

	// route storage
	assign wr_gated = s1_adv ? wr : '0;

	dvru_route_ram u_ram (
		.clk       (clk),
		.wr        (wr_gated),
		.rd_en     (req_acc),
		.nb_idx    (id_to_idx(req.neighbor_id)),
		.dest_idx  (id_to_idx(req.dest_id)),
		.nb_cost   (ram_nb_cost),
		.dest_hop  (ram_dest_hop),
		.dest_cost (ram_dest_cost)
	);

	// forward the most recent table write
	assign nb_hit    = fwd_valid_q && (fwd_idx_q == id_to_idx(item_s1.neighbor_id));
	assign dest_hit  = fwd_valid_q && (fwd_idx_q == id_to_idx(item_s1.dest_id));
	assign nb_cost   = nb_hit ? fwd_cost_q : ram_nb_cost;
	assign dest_hop  = dest_hit ? fwd_hop_q : ram_dest_hop;
	assign dest_cost = dest_hit ? fwd_cost_q : ram_dest_cost;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_gated.en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_gated.en) begin
			fwd_idx_q  <= wr_gated.idx;
			fwd_hop_q  <= wr_gated.next_hop;
			fwd_cost_q <= wr_gated.cost;
		end
	end

	// decision
	dvru_calc u_calc (
		.item          (item_s1),
		.valid_vec     (valid_q),
		.mark_vec      (mark_q),
		.hello_pending (hello_q),
		.nb_cost       (nb_cost),
		.dest_hop      (dest_hop),
		.dest_cost     (dest_cost),
		.wr            (wr),
		.ctl           (ctl),
		.res           (res)
	);

	// valid bits, advert marks, hello flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			mark_q  <= '0;
			hello_q <= 1'b0;
		end else if (s1_adv) begin
			if (wr.en) begin
				valid_q[wr.idx] <= 1'b1;
			end
			if (ctl.msg_end) begin
				mark_q  <= '0;
				hello_q <= 1'b0;
			end else begin
				if (ctl.mark_en) begin
					mark_q[wr.idx] <= 1'b1;
				end
				if (ctl.hello_set) begin
					hello_q <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_rsp_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(s1_valid_s1))
		else $error("result raised without an item in the decision stage");

	a_msg_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && ctl.msg_end) |=> (!hello_q && mark_q == '0))
		else $error("message end did not clear hello flag and marks");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && wr.en) |=> (fwd_valid_q && valid_q[fwd_idx_q]))
		else $error("table write did not leave a valid entry");

	a_changed_is_write: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> (rsp_q.route_changed == $past(wr.en)))
		else $error("route_changed disagrees with table write");

endmodule
